// File: src/ffba_pkg.sv
// ============================================================================
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ============================================================================
package ffba_pkg;

  localparam int unsigned DefMaxBlocks = 255;
  localparam int unsigned DefAddrBits  = 16;

  localparam int unsigned CmdW = 2;
  localparam int unsigned IdW  = 8;
  localparam int unsigned StW  = 2;

  localparam logic [CmdW-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CmdW-1:0] CMD_FREE  = 2'd1;
  localparam logic [CmdW-1:0] CMD_FIND  = 2'd2;

  localparam logic [StW-1:0] ST_OK       = 2'd0;
  localparam logic [StW-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [StW-1:0] ST_NO_ID    = 2'd2;
  localparam logic [StW-1:0] ST_NOT_FND  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;   // capture the request fields
    logic rd_head;    // read the table at the head slot
    logic rd_next;    // read the table at the current next link
    logic rd_find;    // read the table at the requested id slot
    logic step;       // prev <= cur, cur <= next of cur
    logic scan_clr;   // restart the id scan
    logic scan_inc;   // advance the id scan
    logic wr_new;     // write the new entry at the free slot
    logic link_prev;  // point prev at the new slot
    logic head_new;   // make the new slot the head
    logic unlink;     // bypass cur in the chain
    logic set_used;   // mark the new slot in use
    logic clr_used;   // release the matched slot
    logic res_load;   // capture a result
    logic [StW-1:0] res_status;
    logic res_alloc;  // result fields come from the new block
    logic res_cur;    // result fields come from the current entry
  } ffba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic head_nil;
    logic next_nil;   // next of the entry just read is null
    logic gap_fits;   // gap between prev and the entry just read holds the request
    logic match;      // entry just read matches offset and size
    logic fits_heap;  // candidate block ends below the heap size
    logic slot_free;  // scanned id is free
    logic scan_end;   // id scan reached the last slot
    logic find_ok;    // requested id is valid and in use
  } ffba_sts_t;

endpackage

// File: src/first_fit_block_allocator.sv
// ============================================================================
// first_fit_block_allocator
// Address-ordered first-fit allocator with linked block table and id bitmap.
// ============================================================================
//  Channel  Direction  Handshake            Content
//  in_      input      in_tvalid/in_tready  cmd, req_size, req_offset, req_id
//  out_     output     out_tvalid/out_tready status, out_id, out_offset, out_size
//  cfg_     input      cfg_we               heap_bytes
//
//  One command is in flight at a time. Alloc walks the linked table entry by
//  entry, then scans the id bitmap one slot per cycle. Free also walks the
//  table entry by entry. The single-port entry memory sets the walk pace.
//  Reset empties the table at once; a new command waits until the result is taken.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = DefMaxBlocks,
  parameter int unsigned ADDR_BITS  = DefAddrBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // cmd[1:0], req_size[17:2], req_offset[33:18], req_id[41:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[1:0], out_id[9:2], out_offset[25:10], out_size[41:26]
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] heap_bytes_r;
  ffba_cmd_t   cmd;
  ffba_sts_t   sts;
  logic [StW-1:0] res_status;
  logic [IdW-1:0] res_id;
  logic [15:0]    res_offset, res_size;

  // Heap size register.
  always_ff @(posedge clk) begin
    if (!rst_n) heap_bytes_r <= 16'hFFFF;
    else if (cfg_we) heap_bytes_r <= cfg_wdata;
  end

  ffba_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_cmd(in_tdata[1:0]),
    .out_tvalid, .out_tready, .sts, .cmd
  );

  ffba_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst_n, .heap_bytes(heap_bytes_r),
    .req_size(in_tdata[17:2]), .req_offset(in_tdata[33:18]), .req_id(in_tdata[41:34]),
    .cmd, .sts, .res_status, .res_id, .res_offset, .res_size
  );

  assign out_tdata = {6'd0, res_size, res_offset, res_id, res_status};

endmodule

// File: src/ffba_datapath.sv
// ============================================================================
// ffba_datapath
// Link table, entry memories, id bitmap, walk registers and result register.
// ============================================================================
module ffba_datapath import ffba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = DefMaxBlocks,
  parameter int unsigned ADDR_BITS  = DefAddrBits
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          heap_bytes,
  input  logic [15:0]          req_size,
  input  logic [15:0]          req_offset,
  input  logic [IdW-1:0]       req_id,
  input  ffba_cmd_t            cmd,
  output ffba_sts_t            sts,
  output logic [StW-1:0]       res_status,
  output logic [IdW-1:0]       res_id,
  output logic [15:0]          res_offset,
  output logic [15:0]          res_size
);

  localparam int unsigned SlotW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [IdW-1:0] NilLink = IdW'(MAX_BLOCKS);

  // Entry memories; every read is registered.
  logic [IdW-1:0]       next_mem  [MAX_BLOCKS];
  logic [ADDR_BITS-1:0] start_mem [MAX_BLOCKS];
  logic [ADDR_BITS-1:0] len_mem   [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] used_r;

  logic [IdW-1:0]       head_r;
  logic [IdW-1:0]       prev_r, cur_r, scan_r;
  logic [ADDR_BITS-1:0] size_r, off_r;
  logic [IdW-1:0]       id_r;
  logic [IdW-1:0]       rd_next_r;
  logic [ADDR_BITS-1:0] rd_start_r, rd_len_r;
  logic [ADDR_BITS-1:0] prev_end_r;   // end of the entry at prev
  logic [ADDR_BITS:0]   cand_r;       // candidate start of the new block

  logic [IdW-1:0] rd_addr;
  logic           rd_en;
  logic [ADDR_BITS:0] rd_end;

  always_comb begin
    rd_en   = cmd.rd_head | cmd.rd_next | cmd.rd_find;
    rd_addr = cmd.rd_head ? head_r : (cmd.rd_find ? id_r - IdW'(1) : rd_next_r);
  end

  assign rd_end = {1'b0, rd_start_r} + {1'b0, rd_len_r};

  // Registered memory read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_next_r  <= next_mem[rd_addr[SlotW-1:0]];
      rd_start_r <= start_mem[rd_addr[SlotW-1:0]];
      rd_len_r   <= len_mem[rd_addr[SlotW-1:0]];
    end
  end

  // Memory write port: new entry or relink. The new entry inherits the
  // successor of prev, which the walk holds in cur.
  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      start_mem[scan_r[SlotW-1:0]] <= cand_r[ADDR_BITS-1:0];
      len_mem[scan_r[SlotW-1:0]]   <= size_r;
      next_mem[scan_r[SlotW-1:0]]  <= (prev_r == NilLink) ? NilLink : cur_r;
    end else if (cmd.link_prev) begin
      next_mem[prev_r[SlotW-1:0]] <= scan_r;
    end else if (cmd.unlink && prev_r != NilLink) begin
      next_mem[prev_r[SlotW-1:0]] <= rd_next_r;
    end
  end

  // Walk registers and request capture.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      size_r <= ADDR_BITS'(req_size);
      off_r  <= ADDR_BITS'(req_offset);
      id_r   <= req_id;
      prev_r <= NilLink;
      cur_r  <= head_r;
      cand_r <= '0;
    end else if (cmd.rd_head) begin
      cur_r <= head_r;
    end else if (cmd.step) begin
      prev_r     <= cur_r;
      cur_r      <= rd_next_r;
      prev_end_r <= rd_end[ADDR_BITS-1:0];
      cand_r     <= rd_end;
    end
  end

  // Head pointer and id bitmap.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NilLink;
      used_r <= '0;
      scan_r <= '0;
    end else begin
      if (cmd.scan_clr) scan_r <= '0;
      else if (cmd.scan_inc) scan_r <= scan_r + IdW'(1);
      if (cmd.head_new) head_r <= scan_r;
      if (cmd.unlink && prev_r == NilLink) head_r <= rd_next_r;
      if (cmd.set_used) used_r[scan_r[SlotW-1:0]] <= 1'b1;
      if (cmd.clr_used) used_r[cur_r[SlotW-1:0]] <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      if (cmd.res_alloc) begin
        res_id     <= scan_r + IdW'(1);
        res_offset <= 16'(cand_r);
        res_size   <= 16'(size_r);
      end else if (cmd.res_cur) begin
        res_id     <= (cmd.rd_find ? id_r : cur_r + IdW'(1));
        res_offset <= 16'(rd_start_r);
        res_size   <= 16'(rd_len_r);
      end else begin
        res_id     <= '0;
        res_offset <= '0;
        res_size   <= '0;
      end
    end
  end

  always_comb begin
    sts.head_nil  = (head_r == NilLink);
    sts.next_nil  = (rd_next_r == NilLink);
    sts.gap_fits  = (rd_start_r >= prev_end_r) &&
                    ((rd_start_r - prev_end_r) >= size_r);
    sts.match     = (rd_start_r == off_r) && (rd_len_r == size_r);
    sts.fits_heap = ({1'b0, cand_r} + {2'b0, size_r}) < (ADDR_BITS+2)'(heap_bytes);
    sts.slot_free = !used_r[scan_r[SlotW-1:0]];
    sts.scan_end  = (scan_r == IdW'(MAX_BLOCKS - 1));
    sts.find_ok   = (id_r != '0) && (id_r <= IdW'(MAX_BLOCKS)) &&
                    used_r[SlotW'(id_r - IdW'(1))];
  end

endmodule

// File: src/ffba_ctrl.sv
// ============================================================================
// ffba_ctrl
// Command sequencer: table walk, id scan, update and result handshake.
// ============================================================================
module ffba_ctrl import ffba_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [CmdW-1:0] in_cmd,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  ffba_sts_t       sts,
  output ffba_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_A_RD, S_A_CHK, S_A_FIT, S_A_SCAN, S_A_WR, S_A_LINK,
    S_F_RD, S_F_CHK, S_N_RD, S_N_CHK, S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CmdW-1:0] op_r, op_nxt;
  logic            vld_r, vld_nxt;

  assign in_tready  = (state_r == S_IDLE) && !vld_r;
  assign out_tvalid = vld_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    vld_nxt   = vld_r && !out_tready;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load_req = 1'b1;
          op_nxt       = in_cmd;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        case (op_r)
          CMD_ALLOC: begin
            if (sts.head_nil) state_nxt = S_A_FIT;
            else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_A_RD;
            end
          end
          CMD_FREE: begin
            if (sts.head_nil) begin
              cmd.res_load = 1'b1; cmd.res_status = ST_NOT_FND; state_nxt = S_OUT;
            end else begin
              cmd.rd_head = 1'b1; state_nxt = S_N_RD;
            end
          end
          CMD_FIND: begin
            if (sts.find_ok) begin
              cmd.rd_find = 1'b1; state_nxt = S_F_RD;
            end else begin
              cmd.res_load = 1'b1; cmd.res_status = ST_NOT_FND; state_nxt = S_OUT;
            end
          end
          default: begin
            cmd.res_load = 1'b1; cmd.res_status = ST_NOT_FND; state_nxt = S_OUT;
          end
        endcase
      end
      // Entry at cur is being read; then step prev onto it.
      S_A_RD: begin
        cmd.step  = 1'b1;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (sts.next_nil) state_nxt = S_A_FIT;
        else begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_N_CHK;
        end
      end
      // Gap test (alloc) or offset and size match test (free) against the entry after prev.
      S_N_CHK: begin
        if (op_r == CMD_ALLOC) begin
          if (sts.gap_fits) begin
            cmd.rd_head = 1'b0;
            state_nxt   = S_A_FIT;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = S_A_CHK;
          end
        end else begin
          if (sts.match) begin
            cmd.unlink   = 1'b1;
            cmd.clr_used = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_cur  = 1'b1;
            cmd.res_status = ST_OK;
            state_nxt    = S_OUT;
          end else if (sts.next_nil) begin
            cmd.res_load = 1'b1; cmd.res_status = ST_NOT_FND; state_nxt = S_OUT;
          end else begin
            cmd.step    = 1'b1;
            state_nxt   = S_F_CHK;
          end
        end
      end
      S_F_CHK: begin
        cmd.rd_next = 1'b1;
        state_nxt   = S_N_CHK;
      end
      S_N_RD: state_nxt = S_N_CHK;
      S_A_FIT: begin
        if (!sts.fits_heap) begin
          cmd.res_load = 1'b1; cmd.res_status = ST_NO_SPACE; state_nxt = S_OUT;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        if (sts.slot_free) state_nxt = S_A_WR;
        else if (sts.scan_end) begin
          cmd.res_load = 1'b1; cmd.res_status = ST_NO_ID; state_nxt = S_OUT;
        end else cmd.scan_inc = 1'b1;
      end
      S_A_WR: begin
        cmd.wr_new   = 1'b1;
        cmd.set_used = 1'b1;
        state_nxt    = S_A_LINK;
      end
      // Hook the new slot in after prev, or make it the head of an empty table.
      S_A_LINK: begin
        if (sts.head_nil) cmd.head_new = 1'b1;
        else cmd.link_prev = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_alloc  = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_OUT;
      end
      S_F_RD: begin
        cmd.res_load   = 1'b1;
        cmd.res_cur    = 1'b1;
        cmd.rd_find    = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        vld_nxt   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= CMD_ALLOC;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      vld_r   <= vld_nxt;
    end
  end

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("input accepted while a command is in progress");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_tready) |=> vld_r)
    else $error("result dropped before it was taken");
  ap_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.set_used && cmd.clr_used))
    else $error("id set and cleared in the same cycle");

endmodule
